// ===== rtl/core/dqvml_pkg.sv =====
package dqvml_pkg;

  // Sample width of the d/q components (two's complement).
  localparam int SAMPLE_WIDTH = 16;
  localparam int LIMIT_WIDTH  = 15;

  // Magnitude of a sample, which can reach 2^(SAMPLE_WIDTH-1).
  localparam int MAG_W = SAMPLE_WIDTH;
  // Squared magnitude d*d + q*q.
  localparam int SUM_W = 2 * MAG_W + 1;
  // (|v| * L)^2, the remainder bound.
  localparam int REM_W = 2 * (MAG_W + LIMIT_WIDTH);
  // m * S partial product.
  localparam int PRD_W = MAG_W + SUM_W;
  // Trial increment in the digit recurrence.
  localparam int DLT_W = PRD_W + MAG_W + 1;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] d_in;
    logic signed [SAMPLE_WIDTH-1:0] q_in;
  } dq_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] d_out;
    logic signed [SAMPLE_WIDTH-1:0] q_out;
    logic                           was_limited;
  } dq_out_t;

  // One axis of the restoring square-root/divide recurrence.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [PRD_W-1:0] prd;
    logic [MAG_W-1:0] m;
    logic             neg;
  } lane_t;

  // Everything carried alongside the lanes through the digit stages.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             lim;
    dq_in_t           orig;
  } side_t;

endpackage

// ===== rtl/core/dq_vector_magnitude_limiter_core.sv =====
// Throughput: one transaction per cycle; a stall on the output freezes the whole pipeline.
// The pipeline has three front stages (magnitudes, products, squares), one stage
// per result bit of the exact square-root/divide recurrence, and one output register.
// Reset (synchronous, rst_n low) clears all valid bits and sets the limit to zero.
module dq_vector_magnitude_limiter_core
  import dqvml_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LIMIT_WIDTH-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dq_in_t                 in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dq_out_t                out_data
);

  localparam int NS = MAG_W;
  localparam int PL_W = MAG_W + LIMIT_WIDTH;

  logic en;
  logic [LIMIT_WIDTH-1:0] limit_r;

  // Configuration register: always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  // The whole pipeline advances unless the output holds an untaken result.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: magnitudes and signs.
  logic                   v1_r;
  logic [MAG_W-1:0]       dm1_r, qm1_r;
  logic                   dn1_r, qn1_r;
  logic [LIMIT_WIDTH-1:0] l1_r;
  dq_in_t                 o1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn1_r <= in_data.d_in[SAMPLE_WIDTH-1];
      qn1_r <= in_data.q_in[SAMPLE_WIDTH-1];
      dm1_r <= in_data.d_in[SAMPLE_WIDTH-1] ? MAG_W'(-in_data.d_in) : MAG_W'(in_data.d_in);
      qm1_r <= in_data.q_in[SAMPLE_WIDTH-1] ? MAG_W'(-in_data.q_in) : MAG_W'(in_data.q_in);
      l1_r  <= limit_r;
      o1_r  <= in_data;
    end
  end

  // Stage 2: squared magnitude, |v|*L products and L^2.
  logic                     v2_r;
  logic [SUM_W-1:0]         s2_r;
  logic [PL_W-1:0]          pd2_r, pq2_r;
  logic [2*LIMIT_WIDTH-1:0] ll2_r;
  logic                     lz2_r, dn2_r, qn2_r;
  dq_in_t                   o2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r  <= SUM_W'(dm1_r * dm1_r) + SUM_W'(qm1_r * qm1_r);
      pd2_r <= PL_W'(dm1_r) * PL_W'(l1_r);
      pq2_r <= PL_W'(qm1_r) * PL_W'(l1_r);
      ll2_r <= (2*LIMIT_WIDTH)'(l1_r) * (2*LIMIT_WIDTH)'(l1_r);
      lz2_r <= (l1_r == '0);
      dn2_r <= dn1_r;
      qn2_r <= qn1_r;
      o2_r  <= o1_r;
    end
  end

  // Stage 3: remainder seeds (|v|*L)^2 and the limit decision.
  logic  v3_r;
  lane_t ld3_r, lq3_r;
  side_t sd3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld3_r.rem <= REM_W'(pd2_r) * REM_W'(pd2_r);
      ld3_r.prd <= '0;
      ld3_r.m   <= '0;
      ld3_r.neg <= dn2_r;
      lq3_r.rem <= REM_W'(pq2_r) * REM_W'(pq2_r);
      lq3_r.prd <= '0;
      lq3_r.m   <= '0;
      lq3_r.neg <= qn2_r;
      sd3_r.sum  <= s2_r;
      sd3_r.lim  <= !lz2_r && (s2_r > SUM_W'(ll2_r));
      sd3_r.orig <= o2_r;
    end
  end

  // Digit stages: one result bit per stage, most significant first.
  // Each keeps rem = (|v|L)^2 - m^2*S and prd = m*S so a trial needs only shifts and adds.
  logic  vs_r [NS+1];
  lane_t lds_r [NS+1];
  lane_t lqs_r [NS+1];
  side_t sds_r [NS+1];

  assign vs_r[0]  = v3_r;
  assign lds_r[0] = ld3_r;
  assign lqs_r[0] = lq3_r;
  assign sds_r[0] = sd3_r;

  for (genvar i = 0; i < NS; i++) begin : g_digit
    localparam int K = NS - 1 - i;
    logic [DLT_W-1:0] sq_term;
    logic [DLT_W-1:0] dd, dq;
    lane_t            ld_nxt, lq_nxt;

    always_comb begin
      sq_term = DLT_W'(sds_r[i].sum) << (2*K);
      dd = (DLT_W'(lds_r[i].prd) << (K+1)) + sq_term;
      dq = (DLT_W'(lqs_r[i].prd) << (K+1)) + sq_term;
      ld_nxt = lds_r[i];
      lq_nxt = lqs_r[i];
      if (dd <= DLT_W'(lds_r[i].rem)) begin
        ld_nxt.rem  = lds_r[i].rem - REM_W'(dd);
        ld_nxt.prd  = lds_r[i].prd + (PRD_W'(sds_r[i].sum) << K);
        ld_nxt.m[K] = 1'b1;
      end
      if (dq <= DLT_W'(lqs_r[i].rem)) begin
        lq_nxt.rem  = lqs_r[i].rem - REM_W'(dq);
        lq_nxt.prd  = lqs_r[i].prd + (PRD_W'(sds_r[i].sum) << K);
        lq_nxt.m[K] = 1'b1;
      end
    end

    logic  v_r;
    lane_t ld_r, lq_r;
    side_t sd_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= vs_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ld_r <= ld_nxt;
        lq_r <= lq_nxt;
        sd_r <= sds_r[i];
      end
    end

    assign vs_r[i+1]  = v_r;
    assign lds_r[i+1] = ld_r;
    assign lqs_r[i+1] = lq_r;
    assign sds_r[i+1] = sd_r;
  end

  // Output register: restore signs or pass the original pair.
  logic    out_valid_r;
  dq_out_t out_data_r, out_data_nxt;

  always_comb begin
    if (sds_r[NS].lim) begin
      out_data_nxt.d_out = lds_r[NS].neg ? SAMPLE_WIDTH'(-lds_r[NS].m)
                                         : SAMPLE_WIDTH'(lds_r[NS].m);
      out_data_nxt.q_out = lqs_r[NS].neg ? SAMPLE_WIDTH'(-lqs_r[NS].m)
                                         : SAMPLE_WIDTH'(lqs_r[NS].m);
      out_data_nxt.was_limited = 1'b1;
    end else begin
      out_data_nxt.d_out = sds_r[NS].orig.d_in;
      out_data_nxt.q_out = sds_r[NS].orig.q_in;
      out_data_nxt.was_limited = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vs_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
